/* hdl/ctd_pkg.sv */
// Shared types and constants for the hh:mm:ss countdown timer.
// No dependencies; every other file but ctd_if refers to it by scoped names.
package ctd_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_UP     = 3'd1,
    OP_DOWN   = 3'd2,
    OP_SELECT = 3'd3,
    OP_BACK   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PH_EDIT  = 2'd0,
    PH_RUN   = 2'd1,
    PH_PAUSE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  localparam int unsigned MS_W      = 29;
  localparam logic [2:0]  LAST_POS  = 3'd5;
  localparam logic [2:0]  POS_MIN_TENS = 3'd2;
  localparam logic [2:0]  POS_SEC_TENS = 3'd4;
  localparam logic [15:0] BLINK_RESET  = 16'd500;

  // digits[0] is hours tens, digits[5] is seconds ones
  typedef logic [3:0]            digit_t;
  typedef digit_t [5:0]          digits_t;

  typedef struct packed {
    phase_e     phase;
    logic       use_digits;
    digits_t    digits;
    logic       blank_on;
    logic [2:0] blank_pos;
    logic       alarm_start;
    logic       alarm_stop;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [MS_W-1:0] left_ms;
  } ctrl_out_t;

endpackage

/* hdl/ctd_if.sv */
// Handshake channels of the countdown timer: input events and display results.
// Depends on nothing.
interface ctd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        long_press;
  logic [31:0] now_ms;

  modport source (output valid, output op, output long_press, output now_ms, input ready);
  modport sink   (input valid, input op, input long_press, input now_ms, output ready);
endinterface

interface ctd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase_now;
  logic [3:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic       blank_on;
  logic [2:0] blank_pos;
  logic       alarm_start;
  logic       alarm_stop;

  modport source (output valid, output phase_now, output hour_tens, output hour_ones,
                  output minute_tens, output minute_ones, output second_tens,
                  output second_ones, output blank_on, output blank_pos,
                  output alarm_start, output alarm_stop, input ready);
  modport sink   (input valid, input phase_now, input hour_tens, input hour_ones,
                  input minute_tens, input minute_ones, input second_tens,
                  input second_ones, input blank_on, input blank_pos,
                  input alarm_start, input alarm_stop, output ready);
endinterface

/* hdl/ctd_ctrl.sv */
// Timer control: input register, phase/edit/blink state update, result stage.
// Depends on ctd_pkg and ctd_in_if.
module ctd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  ctd_in_if.sink              in_i,
  input  logic [15:0]         blink_interval_i,
  output ctd_pkg::ctrl_out_t  res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i
);

  // input register
  logic        s0_v_q;
  logic [2:0]  s0_op_q;
  logic        s0_lp_q;
  logic [31:0] s0_now_q;

  // timer state
  ctd_pkg::phase_e              phase_q, phase_d;
  ctd_pkg::digits_t             digits_q, digits_d;
  logic [ctd_pkg::MS_W-1:0]     cfg_ms_q, cfg_ms_d;
  logic [ctd_pkg::MS_W-1:0]     rem_q, rem_d;
  logic [31:0]                  run_start_q, run_start_d;
  logic [2:0]                   step_q, step_d;
  logic                         blink_q, blink_d;
  logic [31:0]                  last_blink_q, last_blink_d;

  logic                         s1_v_q;
  ctd_pkg::ctrl_out_t           s1_q, s1_d;
  logic                         s1_rdy, step_en;

  logic [31:0]                  elapsed, since_blink;
  logic [ctd_pkg::MS_W-1:0]     left_cur, edit_ms, weight_ms;
  logic [2:0]                   pos;
  logic [3:0]                   lim_m1, old_d, new_d;
  logic [4:0]                   delta;
  logic                         run_moved, a_start, a_stop;
  ctd_pkg::op_e                 op;

  function automatic logic [ctd_pkg::MS_W-1:0] digit_weight(input logic [2:0] p);
    logic [ctd_pkg::MS_W-1:0] w;
    case (p)
      3'd0:    w = 29'd36000000;
      3'd1:    w = 29'd3600000;
      3'd2:    w = 29'd600000;
      3'd3:    w = 29'd60000;
      3'd4:    w = 29'd10000;
      default: w = 29'd1000;
    endcase
    return w;
  endfunction

  assign s1_rdy     = !s1_v_q || res_ready_i;
  assign step_en    = s0_v_q && s1_rdy;
  assign in_i.ready = !s0_v_q || s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_op_q  <= in_i.op;
      s0_lp_q  <= in_i.long_press;
      s0_now_q <= in_i.now_ms;
    end
  end

  assign op          = ctd_pkg::op_e'(s0_op_q);
  assign elapsed     = s0_now_q - run_start_q;
  assign since_blink = s0_now_q - last_blink_q;
  assign left_cur    = (phase_q != ctd_pkg::PH_RUN) ? rem_q :
                       (elapsed >= {3'b000, rem_q}) ? '0 : rem_q - elapsed[ctd_pkg::MS_W-1:0];

  // digit edit; the set time in ms follows the digit change by its weight
  assign pos       = (step_q > ctd_pkg::LAST_POS) ? ctd_pkg::LAST_POS : step_q;
  assign lim_m1    = (pos == ctd_pkg::POS_MIN_TENS || pos == ctd_pkg::POS_SEC_TENS) ?
                     4'd5 : 4'd9;
  assign old_d     = digits_q[pos];
  assign new_d     = (op == ctd_pkg::OP_UP) ? ((old_d >= lim_m1) ? 4'd0 : old_d + 4'd1) :
                                              ((old_d == 4'd0) ? lim_m1 : old_d - 4'd1);
  assign delta     = {1'b0, new_d} - {1'b0, old_d};
  assign weight_ms = digit_weight(pos);
  assign edit_ms   = cfg_ms_q + {{(ctd_pkg::MS_W-5){delta[4]}}, delta} * weight_ms;

  always_comb begin
    phase_d      = phase_q;
    digits_d     = digits_q;
    cfg_ms_d     = cfg_ms_q;
    rem_d        = rem_q;
    run_start_d  = run_start_q;
    step_d       = step_q;
    blink_d      = blink_q;
    last_blink_d = last_blink_q;
    run_moved    = 1'b0;
    a_start      = 1'b0;
    a_stop       = 1'b0;
    case (op) inside
      ctd_pkg::OP_TICK: begin
        if (phase_q == ctd_pkg::PH_RUN && left_cur == '0) begin
          phase_d = ctd_pkg::PH_DONE;
          rem_d   = '0;
          a_start = 1'b1;
        end
        if (phase_q == ctd_pkg::PH_EDIT && since_blink >= {16'h0000, blink_interval_i}) begin
          last_blink_d = s0_now_q;
          blink_d      = !blink_q;
        end
      end
      ctd_pkg::OP_UP, ctd_pkg::OP_DOWN, ctd_pkg::OP_SELECT, ctd_pkg::OP_BACK: begin
        if (!(s0_lp_q && op == ctd_pkg::OP_SELECT)) begin
          if (phase_q == ctd_pkg::PH_EDIT) begin
            if (op == ctd_pkg::OP_UP || op == ctd_pkg::OP_DOWN) begin
              digits_d[pos] = new_d;
              cfg_ms_d      = edit_ms;
              blink_d       = 1'b0;
              last_blink_d  = s0_now_q;
            end else if (op == ctd_pkg::OP_SELECT) begin
              if (step_q < ctd_pkg::LAST_POS) begin
                step_d       = step_q + 3'd1;
                blink_d      = 1'b0;
                last_blink_d = s0_now_q;
              end else if (cfg_ms_q != '0) begin
                rem_d       = cfg_ms_q;
                run_start_d = s0_now_q;
                phase_d     = ctd_pkg::PH_RUN;
                blink_d     = 1'b0;
                run_moved   = 1'b1;
              end
            end
          end else if (phase_q == ctd_pkg::PH_RUN && op == ctd_pkg::OP_SELECT) begin
            rem_d   = left_cur;
            phase_d = ctd_pkg::PH_PAUSE;
          end else if (phase_q == ctd_pkg::PH_PAUSE && op == ctd_pkg::OP_SELECT) begin
            run_start_d = s0_now_q;
            phase_d     = ctd_pkg::PH_RUN;
            run_moved   = 1'b1;
          end else if ((phase_q == ctd_pkg::PH_DONE && op == ctd_pkg::OP_SELECT) ||
                       op == ctd_pkg::OP_BACK) begin
            phase_d      = ctd_pkg::PH_EDIT;
            rem_d        = cfg_ms_q;
            step_d       = 3'd0;
            blink_d      = 1'b0;
            last_blink_d = s0_now_q;
            a_stop       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_d.tag.phase       = phase_d;
    s1_d.tag.use_digits  = (phase_d == ctd_pkg::PH_EDIT);
    s1_d.tag.digits      = digits_d;
    s1_d.tag.blank_on    = (phase_d == ctd_pkg::PH_EDIT) && blink_d;
    s1_d.tag.blank_pos   = step_d;
    s1_d.tag.alarm_start = a_start;
    s1_d.tag.alarm_stop  = a_stop;
    // after a start or resume the elapsed time is zero
    s1_d.left_ms         = (phase_d == ctd_pkg::PH_RUN && !run_moved) ? left_cur : rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ctd_pkg::PH_EDIT;
      digits_q     <= '0;
      cfg_ms_q     <= '0;
      rem_q        <= '0;
      run_start_q  <= '0;
      step_q       <= '0;
      blink_q      <= 1'b0;
      last_blink_q <= '0;
      s1_v_q       <= 1'b0;
    end else begin
      if (step_en) begin
        phase_q      <= phase_d;
        digits_q     <= digits_d;
        cfg_ms_q     <= cfg_ms_d;
        rem_q        <= rem_d;
        run_start_q  <= run_start_d;
        step_q       <= step_d;
        blink_q      <= blink_d;
        last_blink_q <= last_blink_d;
      end
      if (s1_rdy) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      s1_q <= s1_d;
    end
  end

  assign res_o       = s1_q;
  assign res_valid_o = s1_v_q;

endmodule

/* hdl/ctd_disp.sv */
// Display pipeline: remaining ms to whole seconds (rounded up), then hh:mm:ss
// digits, through reciprocal multiplies; ends in the output register.
// Depends on ctd_pkg and ctd_out_if.
module ctd_disp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctd_pkg::ctrl_out_t  in_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  ctd_out_if.source           out_o
);

  localparam int unsigned NSTG = 5;
  // floor(y/125) for y < 2^27
  localparam logic [27:0] SEC_RECIP  = 28'd137438954;
  // floor(z/225) for z < 2^15
  localparam logic [15:0] HOUR_RECIP = 16'd37283;
  // floor(r/60) for r < 3600
  localparam logic [12:0] MIN_RECIP  = 13'd4370;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;
  ctd_pkg::tag_t   tag_q [NSTG];

  logic [29:0] ms_up;
  logic [54:0] sec_prod;
  logic [30:0] hour_prod;
  logic [18:0] hour_secs, secs_rem;
  logic [24:0] min_prod;
  logic [11:0] min_secs, sec_full;

  logic [18:0] secs0_q, secs1_q;
  logic [6:0]  hour1_q, hour2_q, hour3_q;
  logic [11:0] rem2_q, rem3_q;
  logic [5:0]  min3_q;
  logic [5:0]  sec_val;
  logic [7:0]  hour_dec, min_dec, sec_dec;
  ctd_pkg::tag_t last_tag;

  function automatic logic [7:0] dec_split(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    ones = v - 7'(int'(tens) * 10);
    return {tens, ones[3:0]};
  endfunction

  assign rdy[NSTG]  = out_o.ready;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (rdy[k]) tag_q[k] <= in_data_i.tag;
      end
    end else if (k < NSTG-1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (rdy[k]) tag_q[k] <= tag_q[k-1];
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (rdy[k]) tag_q[k] <= last_tag;
      end
    end
  end

  // ceil(ms/1000) = floor((ms+999)/8/125)
  assign ms_up    = {1'b0, in_data_i.left_ms} + 30'd999;
  assign sec_prod = 55'(ms_up[29:3]) * 55'(SEC_RECIP);

  assign hour_prod = 31'(secs0_q[18:4]) * 31'(HOUR_RECIP);

  assign hour_secs = 19'(hour1_q) * 19'd3600;
  assign secs_rem  = secs1_q - hour_secs;

  assign min_prod  = 25'(rem2_q) * 25'(MIN_RECIP);

  assign min_secs  = 12'(min3_q) * 12'd60;
  assign sec_full  = rem3_q - min_secs;
  assign sec_val   = sec_full[5:0];
  assign hour_dec  = dec_split(hour3_q);
  assign min_dec   = dec_split({1'b0, min3_q});
  assign sec_dec   = dec_split({1'b0, sec_val});

  always_comb begin
    last_tag = tag_q[NSTG-2];
    if (!tag_q[NSTG-2].use_digits) begin
      last_tag.digits[0] = hour_dec[7:4];
      last_tag.digits[1] = hour_dec[3:0];
      last_tag.digits[2] = min_dec[7:4];
      last_tag.digits[3] = min_dec[3:0];
      last_tag.digits[4] = sec_dec[7:4];
      last_tag.digits[5] = sec_dec[3:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) secs0_q <= sec_prod[52:34];
    if (rdy[1]) begin
      secs1_q <= secs0_q;
      hour1_q <= hour_prod[29:23];
    end
    if (rdy[2]) begin
      hour2_q <= hour1_q;
      rem2_q  <= secs_rem[11:0];
    end
    if (rdy[3]) begin
      hour3_q <= hour2_q;
      rem3_q  <= rem2_q;
      min3_q  <= min_prod[23:18];
    end
  end

  assign out_o.valid       = v_q[NSTG-1];
  assign out_o.phase_now   = tag_q[NSTG-1].phase;
  assign out_o.hour_tens   = tag_q[NSTG-1].digits[0];
  assign out_o.hour_ones   = tag_q[NSTG-1].digits[1];
  assign out_o.minute_tens = tag_q[NSTG-1].digits[2][2:0];
  assign out_o.minute_ones = tag_q[NSTG-1].digits[3];
  assign out_o.second_tens = tag_q[NSTG-1].digits[4][2:0];
  assign out_o.second_ones = tag_q[NSTG-1].digits[5];
  assign out_o.blank_on    = tag_q[NSTG-1].blank_on;
  assign out_o.blank_pos   = tag_q[NSTG-1].blank_pos;
  assign out_o.alarm_start = tag_q[NSTG-1].alarm_start;
  assign out_o.alarm_stop  = tag_q[NSTG-1].alarm_stop;

endmodule

/* hdl/countdown_timer_digit_edit.sv */
// Top level of the hh:mm:ss countdown timer with digit editing.
// Depends on ctd_pkg, ctd_if, ctd_ctrl and ctd_disp.
//
//  port         dir  kind             carries
//  in_i         in   valid/ready      op, long_press, now_ms
//  out_o        out  valid/ready      phase, six digits, blink, edit position, alarms
//  cfg_we_i     in   write strobe     blink_interval_ms <= cfg_wdata_i
//
// One event per clock is taken unless back-pressure holds it; a result passes the
// input register, state update, four display stages and the output register.
// The state update is registered; the ms-to-digits path is the 5-stage pipeline.
// Each stage holds under back-pressure only while its successor is full, so
// bubbles still let new events in. Reset clears phase, set time and blink state;
// blink interval returns to 500 ms.
module countdown_timer_digit_edit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctd_in_if.sink      in_i,
  ctd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]        blink_q;
  ctd_pkg::ctrl_out_t ctrl_res;
  logic               ctrl_valid, disp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q <= ctd_pkg::BLINK_RESET;
    end else if (cfg_we_i) begin
      blink_q <= cfg_wdata_i;
    end
  end

  ctd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_i),
    .blink_interval_i (blink_q),
    .res_o            (ctrl_res),
    .res_valid_o      (ctrl_valid),
    .res_ready_i      (disp_ready)
  );

  ctd_disp u_disp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (ctrl_res),
    .in_valid_i (ctrl_valid),
    .in_ready_o (disp_ready),
    .out_o      (out_o)
  );

endmodule

/* hdl/ctd_checker.sv */
// Port-level checks on the countdown timer results, bound to the top level.
// Depends on ctd_pkg and countdown_timer_digit_edit.
module ctd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] phase_i,
  input logic [3:0] hour_tens_i,
  input logic [3:0] hour_ones_i,
  input logic [2:0] minute_tens_i,
  input logic [3:0] minute_ones_i,
  input logic [2:0] second_tens_i,
  input logic [3:0] second_ones_i,
  input logic       blank_on_i,
  input logic [2:0] blank_pos_i,
  input logic       alarm_start_i,
  input logic       alarm_stop_i
);

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alarm_start_i |-> phase_i == ctd_pkg::PH_DONE)
    else $error("alarm start outside done phase");

  a_stop_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alarm_stop_i |->
      phase_i == ctd_pkg::PH_EDIT && blank_pos_i == 3'd0 && !blank_on_i)
    else $error("timer reset did not return to first digit");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && phase_i == ctd_pkg::PH_DONE |->
      hour_tens_i == 4'd0 && hour_ones_i == 4'd0 && minute_tens_i == 3'd0 &&
      minute_ones_i == 4'd0 && second_tens_i == 3'd0 && second_ones_i == 4'd0 &&
      !blank_on_i)
    else $error("done phase shows nonzero time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

endmodule

bind countdown_timer_digit_edit ctd_checker u_ctd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .phase_i       (out_o.phase_now),
  .hour_tens_i   (out_o.hour_tens),
  .hour_ones_i   (out_o.hour_ones),
  .minute_tens_i (out_o.minute_tens),
  .minute_ones_i (out_o.minute_ones),
  .second_tens_i (out_o.second_tens),
  .second_ones_i (out_o.second_ones),
  .blank_on_i    (out_o.blank_on),
  .blank_pos_i   (out_o.blank_pos),
  .alarm_start_i (out_o.alarm_start),
  .alarm_stop_i  (out_o.alarm_stop)
);
